// ===== design/cpmn_pkg.sv =====
// Package for the color pulse median normalizer: widths, register indexes, reset values.
// No dependencies.
package cpmn_pkg;
    localparam int SAMPLES_DEFAULT = 5;
    localparam int WIDTH_W = 16;
    localparam int FREQ_W = 28;
    localparam int NUM_CFG = 6;
    localparam int CFG_IDX_W = 3;
    localparam logic [31:0] FREQ_NUM = 32'd256000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RED_DARK = 3'd0,
        REG_RED_BRIGHT = 3'd1,
        REG_GREEN_DARK = 3'd2,
        REG_GREEN_BRIGHT = 3'd3,
        REG_BLUE_DARK = 3'd4,
        REG_BLUE_BRIGHT = 3'd5
    } cfg_idx_t;

    localparam logic [WIDTH_W-1:0] RST_RED_DARK = 16'd400;
    localparam logic [WIDTH_W-1:0] RST_RED_BRIGHT = 16'd90;
    localparam logic [WIDTH_W-1:0] RST_GREEN_DARK = 16'd1050;
    localparam logic [WIDTH_W-1:0] RST_GREEN_BRIGHT = 16'd235;
    localparam logic [WIDTH_W-1:0] RST_BLUE_DARK = 16'd1350;
    localparam logic [WIDTH_W-1:0] RST_BLUE_BRIGHT = 16'd300;

    // one frame of channel medians handed from front to back
    typedef struct packed {
        logic [WIDTH_W-1:0] clear_med;
        logic [WIDTH_W-1:0] red_med;
        logic [WIDTH_W-1:0] green_med;
        logic [WIDTH_W-1:0] blue_med;
    } frame_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] red_share;
        logic [WIDTH_W-1:0] green_share;
        logic [WIDTH_W-1:0] blue_share;
        logic [FREQ_W-1:0]  clear_frequency;
    } result_t;
endpackage

// ===== design/cpmn_if.sv =====
// Valid/ready channel interfaces for the normalizer.
// Depends on cpmn_pkg.
interface cpmn_in_if;
    logic valid;
    logic ready;
    logic [cpmn_pkg::WIDTH_W-1:0] pulse_width;
    modport source (output valid, output pulse_width, input ready);
    modport sink (input valid, input pulse_width, output ready);
endinterface

interface cpmn_out_if;
    logic valid;
    logic ready;
    logic [cpmn_pkg::WIDTH_W-1:0] red_share;
    logic [cpmn_pkg::WIDTH_W-1:0] green_share;
    logic [cpmn_pkg::WIDTH_W-1:0] blue_share;
    logic [cpmn_pkg::FREQ_W-1:0]  clear_frequency;
    modport source (output valid, output red_share, output green_share,
                    output blue_share, output clear_frequency, input ready);
    modport sink (input valid, input red_share, input green_share,
                  input blue_share, input clear_frequency, output ready);
endinterface

interface cpmn_cfg_if;
    logic valid;
    logic ready;
    logic [cpmn_pkg::CFG_IDX_W-1:0] index;
    logic [cpmn_pkg::WIDTH_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/cpmn_front.sv =====
// Front: collects samples, finds each channel median by rank counting, builds frames.
// Depends on cpmn_pkg.
module cpmn_front #(
    parameter int SAMPLES = cpmn_pkg::SAMPLES_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [cpmn_pkg::WIDTH_W-1:0] in_data,
    output logic frame_valid,
    input  logic frame_ready,
    output cpmn_pkg::frame_t frame
);
    import cpmn_pkg::*;

    localparam int IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int CNT_W = $clog2(SAMPLES + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES - 1);
    localparam logic [CNT_W-1:0] MID = CNT_W'(SAMPLES / 2);

    typedef enum logic [1:0] { S_COLLECT, S_RANK, S_PUSH } state_t;

    state_t state_reg;
    logic [WIDTH_W-1:0] store_reg [SAMPLES];
    logic [CNT_W-1:0] count_reg;
    logic [1:0] chan_reg;
    logic [CNT_W-1:0] cand_reg;
    logic [WIDTH_W-1:0] meds_reg [4];

    // rank test of one candidate: number below, number below or equal-before
    logic [CNT_W-1:0] lt_cnt, le_cnt;
    logic [WIDTH_W-1:0] cand_val;
    logic is_med;
    always_comb
    begin
        cand_val = store_reg[cand_reg[IDX_W-1:0]];
        lt_cnt = '0;
        le_cnt = '0;
        for (int k = 0; k < SAMPLES; k++)
        begin
            if (store_reg[k] < cand_val)
                lt_cnt = lt_cnt + 1'b1;
            if (store_reg[k] < cand_val ||
                (store_reg[k] == cand_val && CNT_W'(k) < cand_reg))
                le_cnt = le_cnt + 1'b1;
        end
        // element whose stable position is MID
        is_med = (le_cnt == MID);
    end

    assign in_ready = (state_reg == S_COLLECT);
    assign frame_valid = (state_reg == S_PUSH);
    assign frame.clear_med = meds_reg[0];
    assign frame.red_med = meds_reg[1];
    assign frame.green_med = meds_reg[2];
    assign frame.blue_med = meds_reg[3];

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            store_reg[count_reg[IDX_W-1:0]] <= in_data;
        if (state_reg == S_RANK && is_med)
            meds_reg[chan_reg] <= cand_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
            count_reg <= '0;
            chan_reg <= '0;
            cand_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_COLLECT:
                begin
                    if (in_valid)
                    begin
                        if (count_reg == LAST)
                        begin
                            count_reg <= '0;
                            cand_reg <= '0;
                            state_reg <= S_RANK;
                        end
                        else
                            count_reg <= count_reg + 1'b1;
                    end
                end
                S_RANK:
                begin
                    if (is_med || cand_reg == LAST)
                    begin
                        chan_reg <= chan_reg + 1'b1;
                        state_reg <= (chan_reg == 2'd3) ? S_PUSH : S_COLLECT;
                    end
                    else
                        cand_reg <= cand_reg + 1'b1;
                end
                S_PUSH:
                begin
                    if (frame_ready)
                        state_reg <= S_COLLECT;
                end
                default: state_reg <= S_COLLECT;
            endcase
        end
    end

    a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=> frame_valid && $stable(frame))
        else $error("frame changed while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RANK |-> !in_ready)
        else $error("sample accepted during rank");
    a_med_found: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RANK && cand_reg == LAST |-> is_med || lt_cnt <= MID)
        else $error("median search ran out");
endmodule

// ===== design/cpmn_queue.sv =====
// Two-entry frame queue between front and back.
// Depends on cpmn_pkg.
module cpmn_queue (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  cpmn_pkg::frame_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output cpmn_pkg::frame_t rd_data
);
    import cpmn_pkg::*;

    frame_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr_en, rd_en;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data = mem_reg[rp_reg];
    assign wr_en = wr_valid && wr_ready;
    assign rd_en = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= ~wp_reg;
            if (rd_en)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count overflow");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wp_reg == rp_reg)
        else $error("queue pointers out of step");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && !rd_en |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count missed write");
endmodule

// ===== design/cpmn_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// No dependencies.
module cpmn_div #(
    parameter int W = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic done,
    output logic [W-1:0] quo
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0] q_reg, d_reg;
    logic [W:0] r_reg;
    logic [CW-1:0] n_reg;
    logic busy_reg;
    logic [W:0] trial;

    assign trial = {r_reg[W-1:0], q_reg[W-1]} - {1'b0, d_reg};
    assign done = busy_reg && (n_reg == '0);
    assign quo = q_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            d_reg <= den;
            r_reg <= '0;
        end
        else if (busy_reg && n_reg != '0)
        begin
            if (!trial[W])
            begin
                r_reg <= trial;
                q_reg <= {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[W-1:0], q_reg[W-1]};
                q_reg <= {q_reg[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            n_reg <= CW'(W);
        end
        else if (busy_reg)
        begin
            if (n_reg == '0)
                busy_reg <= 1'b0;
            else
                n_reg <= n_reg - 1'b1;
        end
    end
endmodule

// ===== design/cpmn_back.sv =====
// Back: scales medians, sums, divides for shares and clear frequency, holds the result.
// Depends on cpmn_pkg and cpmn_div.
module cpmn_back (
    input  logic clk,
    input  logic rst_n,
    input  logic frame_valid,
    output logic frame_ready,
    input  cpmn_pkg::frame_t frame,
    input  logic [cpmn_pkg::WIDTH_W-1:0] cal [cpmn_pkg::NUM_CFG],
    output logic res_valid,
    input  logic res_ready,
    output cpmn_pkg::result_t res
);
    import cpmn_pkg::*;

    typedef enum logic [2:0] { B_IDLE, B_SCALE, B_WAIT, B_SHARE, B_OUT } state_t;

    state_t state_reg;
    frame_t fr_reg;
    logic [1:0] step_reg;
    logic [7:0] sc_reg [3];
    logic [9:0] sum_reg;
    result_t res_reg;
    logic start;
    logic [31:0] num, den;
    logic done;
    logic [31:0] quo;
    logic [WIDTH_W-1:0] med, dark, bright;
    logic neg;
    logic [16:0] dmag, nmag;

    cpmn_div #(.W(32)) u_div (
        .clk(clk), .rst_n(rst_n), .start(start), .num(num), .den(den),
        .done(done), .quo(quo)
    );

    always_comb
    begin
        unique case (step_reg)
            2'd0: begin med = fr_reg.red_med; dark = cal[REG_RED_DARK];
                        bright = cal[REG_RED_BRIGHT]; end
            2'd1: begin med = fr_reg.green_med; dark = cal[REG_GREEN_DARK];
                        bright = cal[REG_GREEN_BRIGHT]; end
            default: begin med = fr_reg.blue_med; dark = cal[REG_BLUE_DARK];
                        bright = cal[REG_BLUE_BRIGHT]; end
        endcase
        // quotient is negative (clamps to 0) when signs differ and nonzero
        dmag = (bright >= dark) ? {1'b0, bright - dark} : {1'b0, dark - bright};
        nmag = (med >= dark) ? {1'b0, med - dark} : {1'b0, dark - med};
        neg = ((med >= dark) != (bright >= dark)) && (med != dark);
        start = 1'b0;
        num = '0;
        den = 32'd1;
        if (state_reg == B_SCALE)
        begin
            start = 1'b1;
            num = 32'(nmag) * 32'd255;
            den = {15'd0, dmag};
        end
        else if (state_reg == B_SHARE && step_reg != 2'd3)
        begin
            start = 1'b1;
            num = {8'd0, sc_reg[step_reg], 16'd0};
            den = {22'd0, sum_reg};
        end
        else if (state_reg == B_SHARE)
        begin
            start = 1'b1;
            num = FREQ_NUM;
            den = {16'd0, fr_reg.clear_med};
        end
    end

    assign frame_ready = (state_reg == B_IDLE);
    assign res_valid = (state_reg == B_OUT);
    assign res = res_reg;

    always_ff @(posedge clk)
    begin
        if (frame_valid && frame_ready)
            fr_reg <= frame;
    end

    logic share_phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            step_reg <= '0;
            share_phase_reg <= 1'b0;
            sum_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                    if (frame_valid)
                    begin
                        step_reg <= '0;
                        share_phase_reg <= 1'b0;
                        state_reg <= B_SCALE;
                    end
                B_SCALE:
                begin
                    state_reg <= B_WAIT;
                    if (dmag == '0 || neg)
                    begin
                        sc_reg[step_reg] <= '0;
                        state_reg <= B_WAIT;
                    end
                end
                B_SHARE: state_reg <= B_WAIT;
                B_WAIT:
                    if (done)
                    begin
                        if (!share_phase_reg)
                        begin
                            if (!(dmag == '0 || neg))
                                sc_reg[step_reg] <= (quo > 32'd255) ? 8'd255 : quo[7:0];
                            if (step_reg == 2'd2)
                            begin
                                sum_reg <= {2'd0, sc_reg[0]} + {2'd0, sc_reg[1]} +
                                    {2'd0, (dmag == '0 || neg) ? 8'd0 :
                                        ((quo > 32'd255) ? 8'd255 : quo[7:0])};
                                step_reg <= '0;
                                share_phase_reg <= 1'b1;
                                state_reg <= B_SHARE;
                            end
                            else
                            begin
                                step_reg <= step_reg + 1'b1;
                                state_reg <= B_SCALE;
                            end
                        end
                        else
                        begin
                            unique case (step_reg)
                                2'd0: res_reg.red_share <= (sum_reg == '0) ? '0 :
                                    ((quo > 32'd65535) ? 16'hFFFF : quo[15:0]);
                                2'd1: res_reg.green_share <= (sum_reg == '0) ? '0 :
                                    ((quo > 32'd65535) ? 16'hFFFF : quo[15:0]);
                                2'd2: res_reg.blue_share <= (sum_reg == '0) ? '0 :
                                    ((quo > 32'd65535) ? 16'hFFFF : quo[15:0]);
                                default: res_reg.clear_frequency <=
                                    (fr_reg.clear_med == '0) ? '0 : quo[FREQ_W-1:0];
                            endcase
                            if (step_reg == 2'd3)
                                state_reg <= B_OUT;
                            else
                            begin
                                step_reg <= step_reg + 1'b1;
                                state_reg <= B_SHARE;
                            end
                        end
                    end
                B_OUT:
                    if (res_ready)
                        state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");
    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_OUT |-> sum_reg <= 10'd765)
        else $error("sum out of range");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == B_SCALE || state_reg == B_SHARE)
        else $error("divider started out of sequence");
endmodule

// ===== design/color_pulse_median_normalizer.sv =====
// Top level of the color pulse median normalizer: config registers, front, queue, back.
// Depends on cpmn_pkg, cpmn_if, cpmn_front, cpmn_queue, cpmn_back.
// After the last sample of a channel the front ranks candidates and accepts no samples meanwhile.
// After the last blue sample the back runs seven serial divides to the result,
// while the front keeps collecting the next frame.
// Reset clears control state and loads the calibration reset values; no clearing pass.
module color_pulse_median_normalizer #(
    parameter int SAMPLES_PER_CHANNEL = cpmn_pkg::SAMPLES_DEFAULT
) (
    input logic clk,
    input logic rst_n,
    cpmn_in_if.sink in_ch,
    cpmn_out_if.source out_ch,
    cpmn_cfg_if.sink cfg
);
    import cpmn_pkg::*;

    logic [WIDTH_W-1:0] cal_reg [NUM_CFG];
    logic fv, fr, qv, qr;
    frame_t fd, qd;
    result_t rs;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg[REG_RED_DARK] <= RST_RED_DARK;
            cal_reg[REG_RED_BRIGHT] <= RST_RED_BRIGHT;
            cal_reg[REG_GREEN_DARK] <= RST_GREEN_DARK;
            cal_reg[REG_GREEN_BRIGHT] <= RST_GREEN_BRIGHT;
            cal_reg[REG_BLUE_DARK] <= RST_BLUE_DARK;
            cal_reg[REG_BLUE_BRIGHT] <= RST_BLUE_BRIGHT;
        end
        else if (cfg.valid && cfg.index < CFG_IDX_W'(NUM_CFG))
            cal_reg[cfg.index] <= cfg.data;
    end

    cpmn_front #(.SAMPLES(SAMPLES_PER_CHANNEL)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .in_data(in_ch.pulse_width), .frame_valid(fv), .frame_ready(fr), .frame(fd)
    );

    cpmn_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(fv), .wr_ready(fr), .wr_data(fd),
        .rd_valid(qv), .rd_ready(qr), .rd_data(qd)
    );

    cpmn_back u_back (
        .clk(clk), .rst_n(rst_n), .frame_valid(qv), .frame_ready(qr), .frame(qd),
        .cal(cal_reg), .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(rs)
    );

    assign out_ch.red_share = rs.red_share;
    assign out_ch.green_share = rs.green_share;
    assign out_ch.blue_share = rs.blue_share;
    assign out_ch.clear_frequency = rs.clear_frequency;
endmodule
